>>> rtl/line_binary_stream_demux_core_defines.svh
// Assertion macros used by the line / binary stream demux core.
`ifndef LINE_BINARY_STREAM_DEMUX_CORE_DEFINES_SVH
`define LINE_BINARY_STREAM_DEMUX_CORE_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define LBSD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lbsd same-cycle check failed");

// Check that the consequent holds in the cycle after the antecedent.
`define LBSD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lbsd next-cycle check failed");

`endif

>>> rtl/lbsd_pkg.sv
// Package for the line / binary stream demux: codes, widths and control structs.
package lbsd_pkg;

  localparam int LINE_BYTES_DEF = 64;
  localparam int LEN_W = 7;

  // Input item kinds
  localparam logic [1:0] MODE_BYTE  = 2'd0;
  localparam logic [1:0] MODE_BEGIN = 2'd1;
  localparam logic [1:0] MODE_ABORT = 2'd2;
  localparam logic [1:0] MODE_TICK  = 2'd3;

  // Result event codes
  localparam logic [2:0] EV_LINE     = 3'd0;
  localparam logic [2:0] EV_CHUNK    = 3'd1;
  localparam logic [2:0] EV_COMPLETE = 3'd2;
  localparam logic [2:0] EV_ERROR    = 3'd3;
  localparam logic [2:0] EV_BEGIN    = 3'd4;

  // Error kinds
  localparam logic [1:0] ERR_LONG    = 2'd0;
  localparam logic [1:0] ERR_TIMEOUT = 2'd1;
  localparam logic [1:0] ERR_ABORT   = 2'd2;
  localparam logic [1:0] ERR_REJECT  = 2'd3;

  // Binary targets
  localparam logic [1:0] TGT_NONE    = 2'd0;
  localparam logic [1:0] TGT_SCANNER = 2'd1;
  localparam logic [1:0] TGT_UPLINK  = 2'd2;

  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EMIT
  } lbsd_state_t;

  typedef struct packed {
    logic take;      // accept the input word this cycle
    logic rd_issue;  // read the line store at the readout index
    logic emit;      // load the fetched line byte into the output register
  } lbsd_cmd_t;

  typedef struct packed {
    logic out_free;    // output register can take a word this cycle
    logic dump_start;  // the presented word ends a non-empty line
    logic rd_last;     // readout index points at the final line byte
  } lbsd_status_t;

endpackage

>>> rtl/line_binary_stream_demux_core.sv
// A result reaches the output register in the cycle after its word is accepted.
// Throughput: one word per cycle while the output register drains; a line feed that
// ends a non-empty line stalls input while the line is read out, each byte taking a read
// of the line store port and then an output load once the output register is free.
// Reset (synchronous, active high) clears the controller, stream state and timeout;
// the line store is not cleared and keeps its old contents.
`include "line_binary_stream_demux_core_defines.svh"

module line_binary_stream_demux_core
  import lbsd_pkg::*;
#(
  parameter int LINE_BYTES = LINE_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [31:0]      cfg_wdata,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       mode,
  input  logic [7:0]       data_byte,
  input  logic [1:0]       target_sel,
  input  logic [31:0]      transfer_size,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [2:0]       event_res,
  output logic [7:0]       out_byte,
  output logic             has_byte,
  output logic [LEN_W-1:0] line_len,
  output logic [1:0]       out_target,
  output logic [1:0]       error_kind,
  output logic             last
);

  lbsd_cmd_t    cmd;
  lbsd_status_t status;

  lbsd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  lbsd_datapath #(
    .LINE_BYTES (LINE_BYTES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .mode          (mode),
    .data_byte     (data_byte),
    .target_sel    (target_sel),
    .transfer_size (transfer_size),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .event_res     (event_res),
    .out_byte      (out_byte),
    .has_byte      (has_byte),
    .line_len      (line_len),
    .out_target    (out_target),
    .error_kind    (error_kind),
    .last          (last)
  );

  // An accepted word never overwrites a result that is still held
  `LBSD_ASSERT_NOW(a_accept_out_free, clk, rst, in_valid && !in_stall, !out_valid || !out_stall)
  // A line byte is only loaded when the output register can take it
  `LBSD_ASSERT_NOW(a_emit_out_free, clk, rst, cmd.emit, status.out_free)
  // Input stays stalled while a line is read out
  `LBSD_ASSERT_NEXT(a_read_stalls_input, clk, rst, cmd.rd_issue, in_stall && !cmd.take)

endmodule

>>> rtl/lbsd_ctrl.sv
// Controller: accepts input words and sequences the line store readout.
module lbsd_ctrl
  import lbsd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  input  lbsd_status_t status,
  output lbsd_cmd_t    cmd
);

  lbsd_state_t state;
  lbsd_state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next   = state;
    cmd          = '0;
    in_stall     = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall = !status.out_free;
        if (in_valid && status.out_free) begin
          cmd.take = 1'b1;
          if (status.dump_start) begin
            state_next = ST_READ;
          end
        end
      end
      ST_READ: begin
        cmd.rd_issue = 1'b1;
        state_next   = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          state_next = status.rd_last ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/lbsd_datapath.sv
// Datapath: stream state, line store, result logic and output register.
module lbsd_datapath
  import lbsd_pkg::*;
#(
  parameter int LINE_BYTES = LINE_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  lbsd_cmd_t        cmd,
  output lbsd_status_t     status,
  input  logic             cfg_we,
  input  logic [31:0]      cfg_wdata,
  input  logic [1:0]       mode,
  input  logic [7:0]       data_byte,
  input  logic [1:0]       target_sel,
  input  logic [31:0]      transfer_size,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [2:0]       event_res,
  output logic [7:0]       out_byte,
  output logic             has_byte,
  output logic [LEN_W-1:0] line_len,
  output logic [1:0]       out_target,
  output logic [1:0]       error_kind,
  output logic             last
);

  localparam int FW = $clog2(LINE_BYTES);
  localparam logic [FW-1:0] FILL_MAX = FW'(LINE_BYTES - 1);

  // Stream state
  logic [31:0]   idle_timeout;
  logic [1:0]    active_target, active_target_next;
  logic [31:0]   expected_count, expected_count_next;
  logic [31:0]   received_count, received_count_next;
  logic [31:0]   idle_ticks, idle_ticks_next;
  logic          cr_seen, cr_seen_next;
  logic          discarding, discarding_next;
  logic [FW-1:0] fill_count, fill_count_next;

  // Line store and readout
  logic [7:0]    line_store [LINE_BYTES];
  logic [7:0]    rd_data;
  logic [FW-1:0] rd_idx;
  logic [FW-1:0] dump_len;

  // Single-result decode for the accepted word
  logic          res_load;
  logic          mem_we;
  logic [2:0]    r_ev;
  logic [7:0]    r_byte;
  logic          r_has;
  logic [1:0]    r_tgt;
  logic [1:0]    r_err;
  logic          is_active;
  logic [31:0]   rx_inc;
  logic [31:0]   tick_inc;
  logic          out_load;

  assign is_active = (active_target != TGT_NONE);
  assign rx_inc    = received_count + 32'd1;
  assign tick_inc  = (idle_ticks == '1) ? idle_ticks : idle_ticks + 32'd1;

  // Status toward the controller
  assign status.out_free   = !out_valid || !out_stall;
  assign status.dump_start = (mode == MODE_BYTE) && !is_active && !discarding &&
                             (data_byte == CH_LF) && (fill_count != '0);
  assign status.rd_last    = (rd_idx == dump_len - FW'(1));

  // Decode the presented word into next state and a result
  always_comb begin
    active_target_next  = active_target;
    expected_count_next = expected_count;
    received_count_next = received_count;
    idle_ticks_next     = idle_ticks;
    cr_seen_next        = cr_seen;
    discarding_next     = discarding;
    fill_count_next     = fill_count;
    res_load            = 1'b0;
    mem_we              = 1'b0;
    r_ev                = EV_ERROR;
    r_byte              = '0;
    r_has               = 1'b0;
    r_tgt               = TGT_NONE;
    r_err               = ERR_LONG;
    unique case (mode)
      MODE_BYTE: begin
        if (is_active) begin
          received_count_next = rx_inc;
          idle_ticks_next     = '0;
          res_load            = 1'b1;
          r_byte              = data_byte;
          r_has               = 1'b1;
          r_tgt               = active_target;
          if (rx_inc == expected_count) begin
            r_ev                = EV_COMPLETE;
            active_target_next  = TGT_NONE;
            expected_count_next = '0;
            received_count_next = '0;
            cr_seen_next        = 1'b0;
          end else begin
            r_ev = EV_CHUNK;
          end
        end else if (discarding) begin
          cr_seen_next = 1'b0;
          if (data_byte == CH_LF) begin
            discarding_next = 1'b0;
            fill_count_next = '0;
          end
        end else if (cr_seen && (data_byte != CH_LF)) begin
          // drop the line: CR without LF
          cr_seen_next    = 1'b0;
          discarding_next = 1'b1;
          fill_count_next = '0;
        end else if (data_byte == CH_CR) begin
          cr_seen_next = 1'b1;
        end else if (data_byte == CH_LF) begin
          cr_seen_next    = 1'b0;
          fill_count_next = '0;
          if (fill_count == '0) begin
            res_load = 1'b1;
            r_ev     = EV_LINE;
          end
        end else if (fill_count >= FILL_MAX) begin
          // line too long: drop through the next LF
          cr_seen_next    = 1'b0;
          discarding_next = 1'b1;
          fill_count_next = '0;
          res_load        = 1'b1;
          r_err           = ERR_LONG;
        end else begin
          mem_we          = 1'b1;
          fill_count_next = fill_count + FW'(1);
        end
      end
      MODE_BEGIN: begin
        res_load = 1'b1;
        if (is_active || ((target_sel != TGT_SCANNER) && (target_sel != TGT_UPLINK)) ||
            (transfer_size == '0)) begin
          r_tgt = active_target;
          r_err = ERR_REJECT;
        end else begin
          active_target_next  = target_sel;
          expected_count_next = transfer_size;
          received_count_next = '0;
          idle_ticks_next     = '0;
          cr_seen_next        = 1'b0;
          r_ev                = EV_BEGIN;
          r_tgt               = target_sel;
        end
      end
      MODE_ABORT: begin
        res_load            = 1'b1;
        r_tgt               = active_target;
        r_err               = ERR_ABORT;
        active_target_next  = TGT_NONE;
        expected_count_next = '0;
        received_count_next = '0;
        idle_ticks_next     = '0;
        cr_seen_next        = 1'b0;
      end
      MODE_TICK: begin
        if (is_active) begin
          idle_ticks_next = tick_inc;
          if ((idle_timeout != '0) && (tick_inc >= idle_timeout)) begin
            res_load            = 1'b1;
            r_tgt               = active_target;
            r_err               = ERR_TIMEOUT;
            active_target_next  = TGT_NONE;
            expected_count_next = '0;
            received_count_next = '0;
            idle_ticks_next     = '0;
            cr_seen_next        = 1'b0;
          end
        end
      end
      default: begin
        res_load = 1'b0;
      end
    endcase
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      idle_timeout <= '0;
    end else if (cfg_we) begin
      idle_timeout <= cfg_wdata;
    end
  end

  // Advance stream state on an accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      active_target  <= TGT_NONE;
      expected_count <= '0;
      received_count <= '0;
      idle_ticks     <= '0;
      cr_seen        <= 1'b0;
      discarding     <= 1'b0;
      fill_count     <= '0;
    end else if (cmd.take) begin
      active_target  <= active_target_next;
      expected_count <= expected_count_next;
      received_count <= received_count_next;
      idle_ticks     <= idle_ticks_next;
      cr_seen        <= cr_seen_next;
      discarding     <= discarding_next;
      fill_count     <= fill_count_next;
    end
  end

  // Readout index and latched line length
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx   <= '0;
      dump_len <= '0;
    end else if (cmd.take && status.dump_start) begin
      rd_idx   <= '0;
      dump_len <= fill_count;
    end else if (cmd.emit) begin
      rd_idx <= rd_idx + FW'(1);
    end
  end

  // Line store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.take && mem_we) begin
      line_store[fill_count] <= data_byte;
    end
    if (cmd.rd_issue) begin
      rd_data <= line_store[rd_idx];
    end
  end

  // Output register valid
  assign out_load = (cmd.take && res_load) || cmd.emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      event_res  <= EV_LINE;
      out_byte   <= rd_data;
      has_byte   <= 1'b1;
      line_len   <= LEN_W'(dump_len);
      out_target <= TGT_NONE;
      error_kind <= ERR_LONG;
      last       <= status.rd_last;
    end else if (cmd.take && res_load) begin
      event_res  <= r_ev;
      out_byte   <= r_byte;
      has_byte   <= r_has;
      line_len   <= '0;
      out_target <= r_tgt;
      error_kind <= r_err;
      last       <= 1'b1;
    end
  end

endmodule
